// File: rtl/lfg_pkg.sv
// lfg_pkg: constants, types and small decoders for the lagged fibonacci generator
// used by lagged_fibonacci_uniform_rng; depends on nothing else
`timescale 1ns / 1ps

package lfg_pkg;

  // request kinds on the action field
  localparam logic ActReseed = 1'b0;
  localparam logic ActDraw   = 1'b1;

  // ring geometry
  localparam int unsigned RingLen   = 607;
  localparam int unsigned ShortLag  = 273;
  localparam int unsigned LagOffset = RingLen - ShortLag;
  localparam int unsigned FracW     = 24;
  localparam int unsigned AddrW     = 10;
  localparam int unsigned SeedW     = 15;

  // combination generator
  localparam int unsigned DefaultSeed = 1802;
  localparam int unsigned SecondSeed  = 9373;
  localparam int unsigned ModAb       = 179;
  localparam int unsigned ModD        = 169;
  localparam int unsigned ModInit     = 177;
  localparam int unsigned DMul        = 53;
  localparam int unsigned CInit       = (SecondSeed / ModD) % (ModAb - 1) + 1;
  localparam int unsigned DInit       = SecondSeed % ModD;
  localparam int unsigned ResW        = 8;
  localparam int unsigned BitsPerWord = FracW;
  localparam int unsigned BitCntW     = 5;

  // reciprocal reduction: q = (p * floor(2^RecipShift / k)) >> RecipShift
  localparam int unsigned RecipShift  = 23;
  localparam int unsigned MulW        = 16;
  localparam int unsigned ProdW       = 32;
  localparam int unsigned PW          = 15;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [FracW-1:0] frac_t;
  typedef logic [ResW-1:0]  res_t;
  typedef logic [MulW-1:0]  mul_t;
  typedef logic [ProdW-1:0] prod_t;

  localparam addr_t LastAddr     = addr_t'(RingLen - 1);
  localparam addr_t PartnerStart = addr_t'(LagOffset);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_RD,
    ST_DRAW_OUT,
    ST_REGEN_RD,
    ST_REGEN_WR,
    ST_SEED_MUL,
    ST_SEED_RECIP,
    ST_SEED_QK,
    ST_SEED_FIX,
    ST_SEED_BIT,
    ST_SEED_ACC
  } state_e;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_AB,
    OP_MC,
    OP_D
  } seed_op_e;

  function automatic res_t op_modulus(seed_op_e op);
    res_t k;
    unique case (op)
      OP_INIT: k = res_t'(ModInit);
      OP_D:    k = res_t'(ModD);
      default: k = res_t'(ModAb);
    endcase
    return k;
  endfunction

  function automatic mul_t op_recip(seed_op_e op);
    mul_t r;
    unique case (op)
      OP_INIT: r = mul_t'((1 << RecipShift) / ModInit);
      OP_D:    r = mul_t'((1 << RecipShift) / ModD);
      default: r = mul_t'((1 << RecipShift) / ModAb);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/lagged_fibonacci_uniform_rng.sv
// lagged_fibonacci_uniform_rng: additive lagged fibonacci generator, lags 607 and 273
// ring memory, one shared multiplier for reseeding, sequencer; depends on lfg_pkg
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   action_i (1), seed_i (15)
// out       output     out_valid_o / out_ready_i uniform_value_o (24)
//
// a draw request runs through accept, ring read and load of the output register
// after the draw of the last entry the ring is rebuilt in place, read then write per entry
// a reseed request fills all 607 entries, 24 bits each, on the shared multiplier
// after reset a clearing pass writes zeros over the ring, not ready meanwhile
// in_ready_o is high only when the sequencer is idle; a stalled result waits in
// the output register while the next request is taken

module lagged_fibonacci_uniform_rng (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [lfg_pkg::SeedW-1:0]  seed_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lfg_pkg::FracW-1:0]  uniform_value_o
);

  // ring memory, two read ports with registered data, one write port
  lfg_pkg::frac_t ring_mem [lfg_pkg::RingLen];
  lfg_pkg::frac_t rd_a_q, rd_b_q;
  lfg_pkg::addr_t rd_addr_a, rd_addr_b, mem_waddr;
  lfg_pkg::frac_t mem_wdata;
  logic           mem_we;

  // sequencer state
  lfg_pkg::state_e  state_q, state_d;
  lfg_pkg::seed_op_e op_q, op_d;
  lfg_pkg::addr_t   idx_q, idx_d;          // entry under clear, rebuild or reseed
  lfg_pkg::addr_t   partner_q, partner_d;  // entry 273 back during rebuild
  lfg_pkg::addr_t   pos_q, pos_d;          // read position
  logic [lfg_pkg::BitCntW-1:0] bit_cnt_q, bit_cnt_d;

  // reseed datapath
  lfg_pkg::frac_t acc_q, acc_d;
  lfg_pkg::res_t  a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, m1_q, m1_d, quo_q, quo_d;
  logic [lfg_pkg::PW-1:0] p_q, p_d;
  lfg_pkg::prod_t prod_q, prod_d;

  // output register
  logic           out_valid_q, out_valid_d;
  lfg_pkg::frac_t out_value_q, out_value_d;

  // shared multiplier
  lfg_pkg::mul_t mul_x, mul_y;
  logic          mul_add;

  // remainder fix-up: p - q*k lies below 2k
  lfg_pkg::res_t          modulus;
  logic [lfg_pkg::MulW-1:0] fix_diff;
  logic [lfg_pkg::ResW:0] fix_res9;
  logic                   fix_ge;
  lfg_pkg::res_t          fix_res;
  lfg_pkg::res_t          quo_adj, a_init;

  assign in_ready_o      = (state_q == lfg_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign uniform_value_o = out_value_q;

  assign prod_d = lfg_pkg::prod_t'(mul_x) * lfg_pkg::prod_t'(mul_y)
                + lfg_pkg::prod_t'(mul_add);

  always_comb begin
    modulus  = lfg_pkg::op_modulus(op_q);
    fix_diff = {1'b0, p_q} - prod_q[lfg_pkg::MulW-1:0];
    fix_res9 = fix_diff[lfg_pkg::ResW:0];
    fix_ge   = (fix_res9 >= {1'b0, modulus});
    fix_res  = fix_ge ? lfg_pkg::res_t'(fix_res9 - {1'b0, modulus})
                      : fix_res9[lfg_pkg::ResW-1:0];
    // quotient of the seed by 177, then reduced mod 177
    quo_adj  = quo_q + lfg_pkg::res_t'(fix_ge);
    a_init   = ((quo_adj >= lfg_pkg::res_t'(lfg_pkg::ModInit))
                ? quo_adj - lfg_pkg::res_t'(lfg_pkg::ModInit) : quo_adj)
               + lfg_pkg::res_t'(2);
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    partner_d   = partner_q;
    pos_d       = pos_q;
    bit_cnt_d   = bit_cnt_q;
    acc_d       = acc_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    m1_d        = m1_q;
    quo_d       = quo_q;
    p_d         = p_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    rd_addr_a   = pos_q;
    rd_addr_b   = partner_q;
    mul_x       = '0;
    mul_y       = '0;
    mul_add     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lfg_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx_q == lfg_pkg::LastAddr) begin
          idx_d   = '0;
          state_d = lfg_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      lfg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == lfg_pkg::ActDraw) begin
            state_d = lfg_pkg::ST_DRAW_RD;
          end else begin
            p_d       = (seed_i == '0) ? lfg_pkg::PW'(lfg_pkg::DefaultSeed) : seed_i;
            c_d       = lfg_pkg::res_t'(lfg_pkg::CInit);
            d_d       = lfg_pkg::res_t'(lfg_pkg::DInit);
            op_d      = lfg_pkg::OP_INIT;
            bit_cnt_d = '0;
            idx_d     = '0;
            state_d   = lfg_pkg::ST_SEED_MUL;
          end
        end
      end

      lfg_pkg::ST_DRAW_RD: begin
        state_d = lfg_pkg::ST_DRAW_OUT;
      end

      lfg_pkg::ST_DRAW_OUT: begin
        // hold the read address so rd_a_q keeps the entry while the output stalls
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = rd_a_q;
          if (pos_q == lfg_pkg::LastAddr) begin
            pos_d     = '0;
            idx_d     = '0;
            partner_d = lfg_pkg::PartnerStart;
            state_d   = lfg_pkg::ST_REGEN_RD;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = lfg_pkg::ST_IDLE;
          end
        end
      end

      lfg_pkg::ST_REGEN_RD: begin
        rd_addr_a = idx_q;
        state_d   = lfg_pkg::ST_REGEN_WR;
      end

      lfg_pkg::ST_REGEN_WR: begin
        // in place: entries from 273 on pair with rebuilt partners, lower ones with old values
        mem_we    = 1'b1;
        mem_wdata = rd_a_q + rd_b_q;
        partner_d = (partner_q == lfg_pkg::LastAddr) ? '0 : partner_q + 1'b1;
        if (idx_q == lfg_pkg::LastAddr) begin
          idx_d   = '0;
          state_d = lfg_pkg::ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = lfg_pkg::ST_REGEN_RD;
        end
      end

      lfg_pkg::ST_SEED_MUL: begin
        case (op_q)
          lfg_pkg::OP_INIT: begin
            mul_x = lfg_pkg::mul_t'(p_q);
            mul_y = lfg_pkg::mul_t'(1);
          end
          lfg_pkg::OP_AB: begin
            mul_x = lfg_pkg::mul_t'(a_q);
            mul_y = lfg_pkg::mul_t'(b_q);
          end
          lfg_pkg::OP_MC: begin
            mul_x = lfg_pkg::mul_t'(m1_q);
            mul_y = lfg_pkg::mul_t'(c_q);
          end
          default: begin
            mul_x   = lfg_pkg::mul_t'(d_q);
            mul_y   = lfg_pkg::mul_t'(lfg_pkg::DMul);
            mul_add = 1'b1;
          end
        endcase
        state_d = lfg_pkg::ST_SEED_RECIP;
      end

      lfg_pkg::ST_SEED_RECIP: begin
        p_d     = prod_q[lfg_pkg::PW-1:0];
        mul_x   = lfg_pkg::mul_t'(prod_q[lfg_pkg::PW-1:0]);
        mul_y   = lfg_pkg::op_recip(op_q);
        state_d = lfg_pkg::ST_SEED_QK;
      end

      lfg_pkg::ST_SEED_QK: begin
        quo_d   = prod_q[lfg_pkg::RecipShift +: lfg_pkg::ResW];
        mul_x   = lfg_pkg::mul_t'(prod_q[lfg_pkg::RecipShift +: lfg_pkg::ResW]);
        mul_y   = lfg_pkg::mul_t'(modulus);
        state_d = lfg_pkg::ST_SEED_FIX;
      end

      lfg_pkg::ST_SEED_FIX: begin
        case (op_q)
          lfg_pkg::OP_INIT: begin
            a_d     = a_init;
            b_d     = fix_res + lfg_pkg::res_t'(2);
            op_d    = lfg_pkg::OP_AB;
            state_d = lfg_pkg::ST_SEED_MUL;
          end
          lfg_pkg::OP_AB: begin
            m1_d    = fix_res;
            op_d    = lfg_pkg::OP_MC;
            state_d = lfg_pkg::ST_SEED_MUL;
          end
          lfg_pkg::OP_MC: begin
            a_d     = b_q;
            b_d     = c_q;
            c_d     = fix_res;
            op_d    = lfg_pkg::OP_D;
            state_d = lfg_pkg::ST_SEED_MUL;
          end
          default: begin
            d_d     = fix_res;
            state_d = lfg_pkg::ST_SEED_BIT;
          end
        endcase
      end

      lfg_pkg::ST_SEED_BIT: begin
        // new bit is bit 5 of d * m, m now sits in c
        mul_x   = lfg_pkg::mul_t'(d_q);
        mul_y   = lfg_pkg::mul_t'(c_q);
        state_d = lfg_pkg::ST_SEED_ACC;
      end

      lfg_pkg::ST_SEED_ACC: begin
        acc_d   = {acc_q[lfg_pkg::FracW-2:0], prod_q[5]};
        op_d    = lfg_pkg::OP_AB;
        state_d = lfg_pkg::ST_SEED_MUL;
        if (bit_cnt_q == lfg_pkg::BitCntW'(lfg_pkg::BitsPerWord - 1)) begin
          mem_we    = 1'b1;
          mem_wdata = acc_d;
          bit_cnt_d = '0;
          if (idx_q == lfg_pkg::LastAddr) begin
            idx_d   = '0;
            state_d = lfg_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          bit_cnt_d = bit_cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = lfg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfg_pkg::ST_CLEAR;
      op_q        <= lfg_pkg::OP_INIT;
      idx_q       <= '0;
      partner_q   <= '0;
      pos_q       <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      partner_q   <= partner_d;
      pos_q       <= pos_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    a_q         <= a_d;
    b_q         <= b_d;
    c_q         <= c_d;
    d_q         <= d_d;
    m1_q        <= m1_d;
    quo_q       <= quo_d;
    p_q         <= p_d;
    prod_q      <= prod_d;
    out_value_q <= out_value_d;
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= ring_mem[rd_addr_a];
    rd_b_q <= ring_mem[rd_addr_b];
  end

endmodule

// File: rtl/lfg_checker.sv
// lfg_checker: port-level assertions for lagged_fibonacci_uniform_rng
// bound to the top level below; depends on nothing else
`timescale 1ns / 1ps

module lfg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        action_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [23:0] uniform_value_o
);

  // a result stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(uniform_value_o))
    else $error("stalled result changed");

  // a reseed request keeps the block busy afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !action_i |=> !in_ready_o)
    else $error("ready right after a reseed request");

  // a new result only appears after the block has been busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a draw in progress");

endmodule

bind lagged_fibonacci_uniform_rng lfg_checker u_lfg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .action_i        (action_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .uniform_value_o (uniform_value_o)
);

// File: verif/tb_top.sv
// tb_top: self-checking bench for lagged_fibonacci_uniform_rng, draw and reseed requests
// checked against a ring model kept inside the bench; depends on lfg_pkg and the rng top
`timescale 1ns / 1ps

module tb_top;

  // request kinds on action_i
  localparam logic ActReseed = lfg_pkg::ActReseed;
  localparam logic ActDraw   = lfg_pkg::ActDraw;

  localparam int unsigned NumRandom   = 1020;
  localparam int unsigned QuietTail   = 150;
  // a reseed alone keeps both channels silent, so the limit lies above a whole reseed
  localparam int unsigned StallLimit  = 800_000;
  // the drain must outlast a ring rebuild after the last draw
  localparam int unsigned DrainCycles = 1300;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned MaxReports  = 10;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      action_i;
  logic [lfg_pkg::SeedW-1:0] seed_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [lfg_pkg::FracW-1:0] uniform_value_o;

  // ring model and read pointer, updated when a request is accepted
  lfg_pkg::frac_t ring_model [lfg_pkg::RingLen];
  int unsigned    next_pos;
  // uniform values still owed by the block, oldest first
  lfg_pkg::frac_t expected_values [$];

  int unsigned fail_count    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned long_hold_len = 0;
  bit          idle_en       = 1'b1;

  lagged_fibonacci_uniform_rng i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .seed_i         (seed_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .uniform_value_o(uniform_value_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void clear_model();
    int unsigned n;
    for (n = 0; n < lfg_pkg::RingLen; n++) ring_model[n] = '0;
    next_pos = 0;
  endfunction

  // refill the ring from the combination generator, read pointer kept
  function automatic void reseed_model(logic [lfg_pkg::SeedW-1:0] seed_val);
    int unsigned ij, a, b, c, d, m, acc, e, k;
    ij = (seed_val == '0) ? lfg_pkg::DefaultSeed : 32'(seed_val);
    a  = (ij / lfg_pkg::ModInit) % lfg_pkg::ModInit + 2;
    b  = ij % lfg_pkg::ModInit + 2;
    c  = (lfg_pkg::SecondSeed / lfg_pkg::ModD) % (lfg_pkg::ModAb - 1) + 1;
    d  = lfg_pkg::SecondSeed % lfg_pkg::ModD;
    for (e = 0; e < lfg_pkg::RingLen; e++) begin
      acc = 0;
      // msb first, one bit per step of the three-term product
      for (k = 0; k < lfg_pkg::FracW; k++) begin
        m   = ((a * b) % lfg_pkg::ModAb * c) % lfg_pkg::ModAb;
        a   = b;
        b   = c;
        c   = m;
        d   = (d * lfg_pkg::DMul + 1) % lfg_pkg::ModD;
        acc = (acc << 1) | ((((d * m) % 64) >= 32) ? 1 : 0);
      end
      ring_model[e] = lfg_pkg::frac_t'(acc);
    end
  endfunction

  // value of the next draw; rebuilds the ring after its last entry
  function automatic lfg_pkg::frac_t predict_draw();
    lfg_pkg::frac_t value;
    int unsigned    n;
    if (next_pos >= lfg_pkg::RingLen) next_pos = 0;
    value = ring_model[next_pos];
    if (next_pos + 1 >= lfg_pkg::RingLen) begin
      // in place: entries below the short lag pair with old values, the rest with new
      for (n = 0; n < lfg_pkg::RingLen; n++) begin
        ring_model[n] = ring_model[n]
                      + ring_model[(n + lfg_pkg::LagOffset) % lfg_pkg::RingLen];
      end
      next_pos = 0;
    end else begin
      next_pos = next_pos + 1;
    end
    return value;
  endfunction

  // offer one request from a falling edge, return at the falling edge after it is taken
  task automatic send_request(input logic act, input logic [lfg_pkg::SeedW-1:0] seed_val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    seed_i     = seed_val;
    do @(posedge clk_i); while (!in_ready_o);
    if (act == ActDraw) begin
      expected_values.push_back(predict_draw());
    end else begin
      reseed_model(seed_val);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // the seed field is ignored on a draw, so it carries noise
  task automatic send_draw();
    send_request(ActDraw, lfg_pkg::SeedW'($urandom_range(0, (1 << lfg_pkg::SeedW) - 1)));
  endtask

  task automatic wait_for_results();
    while (expected_values.size() != 0) @(negedge clk_i);
  endtask

  // ring is all zeros after reset, so draws return zero
  task automatic test_zero_ring();
    repeat (4) send_draw();
  endtask

  // seed 0 selects the default seed; taken mid-ring, pointer kept
  task automatic test_default_seed();
    send_request(ActReseed, '0);
    repeat (6) send_draw();
  endtask

  // all-ones seed, above the nominal seed range, used as given
  task automatic test_top_seed();
    send_request(ActReseed, '1);
    repeat (6) send_draw();
  endtask

  // long receiver hold: output register fills and the input stalls
  task automatic test_output_stall();
    long_hold_len = LongHold;
    repeat (10) send_draw();
  endtask

  // sender goes quiet until every pending value has come back
  task automatic test_pause_and_drain();
    repeat (5) send_draw();
    wait_for_results();
    repeat (5) send_draw();
  endtask

  // mostly draws, crossing the ring end, with one reseed at a random point
  task automatic test_random_stream();
    int unsigned reseed_at, n;
    reseed_at = $urandom_range(200, 700);
    for (n = 0; n < NumRandom; n++) begin
      if (n % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if (n >= NumRandom - QuietTail) idle_en = 1'b0;
      if (n == reseed_at) begin
        send_request(ActReseed,
                     lfg_pkg::SeedW'($urandom_range(1, (1 << lfg_pkg::SeedW) - 2)));
      end else begin
        send_draw();
      end
    end
  endtask

  // output side: random stall bursts, plus the long hold on request
  initial begin : result_drain
    int unsigned burst;
    burst       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_len != 0) begin
        out_ready_i = 1'b0;
        repeat (long_hold_len) @(negedge clk_i);
        long_hold_len = 0;
        out_ready_i   = 1'b1;
      end else if (burst != 0) begin
        out_ready_i = 1'b0;
        burst--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        burst       = $urandom_range(0, 18);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // compare each taken result with the oldest pending value
  always @(posedge clk_i) begin : check_results
    lfg_pkg::frac_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_values.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("uniform_value_o unexpected: got %h with nothing pending", uniform_value_o);
        end
      end else begin
        want = expected_values.pop_front();
        if (uniform_value_o !== want) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("uniform_value_o wrong: expected %h got %h", want, uniform_value_o);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("lagged_fibonacci_uniform_rng: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = ActDraw;
    seed_i     = '0;
    clear_model();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_ring();
    test_default_seed();
    test_top_seed();
    test_output_stall();
    test_pause_and_drain();
    test_random_stream();

    wait_for_results();
    // let a ring rebuild finish and catch any stray result
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && expected_values.size() == 0) begin
      $display("lagged_fibonacci_uniform_rng: match");
    end else begin
      $display("lagged_fibonacci_uniform_rng: mismatch");
    end
    $finish;
  end

endmodule
